// File: hw/rtl/cif_pkg.sv
// shared constants, payload structs and stage-to-stage structs for the contact force pipeline
// no dependencies; imported by every module under hw/rtl
package cif_pkg;

  localparam int FRAC_BITS = 16;

  localparam int DW       = 32;
  localparam int CFG_IDXW = 3;
  localparam int RESTW    = 17;
  localparam int DTW      = 17;

  // direction path
  localparam int MAGW = 33;
  localparam int PMW  = 30;
  localparam int SUMW = 62;
  localparam int LENW = 31;
  localparam int NB   = FRAC_BITS + 1;
  localparam int NRMW = FRAC_BITS + 2;
  localparam int VRW  = 33;

  // impulse path
  localparam int PRODW = VRW + NRMW;
  localparam int DOTW  = PRODW + 2;
  localparam int ADW   = DOTW - 1 - FRAC_BITS;
  localparam int OW    = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
  localparam int NUMW  = ADW + OW - FRAC_BITS;
  localparam int MUW   = 32;
  localparam int JW    = 63;
  localparam int QB    = 32 + FRAC_BITS;
  localparam int FMW   = QB + 1;

  // stage counts
  localparam int DIR_LAT  = 4 + LENW + NB;
  localparam int MASS_LAT = 1 + MUW;
  localparam int MASS_PAD = DIR_LAT - MASS_LAT;

  // register indexes
  localparam logic [CFG_IDXW-1:0] REG_RESTITUTION = CFG_IDXW'(0);
  localparam logic [CFG_IDXW-1:0] REG_BODY_VEL_X  = CFG_IDXW'(1);
  localparam logic [CFG_IDXW-1:0] REG_BODY_VEL_Y  = CFG_IDXW'(2);
  localparam logic [CFG_IDXW-1:0] REG_BODY_VEL_Z  = CFG_IDXW'(3);
  localparam logic [CFG_IDXW-1:0] REG_TIME_STEP   = CFG_IDXW'(4);

  localparam logic [RESTW-1:0] REST_RST = RESTW'(32768);
  localparam logic [DTW-1:0]   TS_RST   = DTW'(1092);

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  typedef struct packed {
    logic        [31:0] mass_self;
    logic        [31:0] mass_other;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic signed [31:0] contact_z;
    logic signed [31:0] other_vel_x;
    logic signed [31:0] other_vel_y;
    logic signed [31:0] other_vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic        [1:0]  status;
  } out_item_t;

  typedef logic [2:0][DW-1:0] vel_t;

  typedef struct packed {
    logic [2:0][NRMW-1:0] nrm;
    logic [2:0][VRW-1:0]  vr;
    logic                 degen;
  } dir_t;

  typedef struct packed {
    logic [FMW-1:0]       fmag;
    logic [2:0][NRMW-1:0] nrm;
    logic                 degen;
  } imp_t;

endpackage

// File: hw/rtl/cif_dir.sv
// direction path: difference, prescale, squared length, pipelined square root and normal divide
// depends on cif_pkg
module cif_dir (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cif_pkg::in_item_t item_i,
  input  cif_pkg::vel_t     vel_i,
  output logic              valid_o,
  output cif_pkg::dir_t     dir_o
);
  import cif_pkg::*;

  typedef struct packed {
    logic [2:0][PMW-1:0] pm;
    logic [2:0][VRW-1:0] vr;
    logic                degen;
  } side_t;

  typedef struct packed {
    logic [SUMW-1:0] rem;
    logic [LENW-1:0] res;
  } sq_t;

  typedef struct packed {
    logic [2:0][LENW:0] r;
    logic [2:0][NB-1:0] l;
    logic [2:0][NB-1:0] q;
  } dv_t;

  function automatic sq_t sqrt_step(sq_t s, int k);
    sq_t             o;
    logic [SUMW-1:0] t;
    t = (SUMW'(s.res) << (k + 1)) + (SUMW'(1) << (2 * k));
    o = s;
    if (s.rem >= t) begin
      o.rem = s.rem - t;
      o.res = s.res | (LENW'(1) << k);
    end
    return o;
  endfunction

  function automatic dv_t div_step(dv_t s, logic [LENW-1:0] len);
    dv_t         o;
    logic [LENW:0] t;
    o = s;
    for (int i = 0; i < 3; i++) begin
      t      = {s.r[i][LENW-1:0], s.l[i][NB-1]};
      o.l[i] = s.l[i] << 1;
      if (t >= {1'b0, len}) begin
        o.r[i] = t - {1'b0, len};
        o.q[i] = {s.q[i][NB-2:0], 1'b1};
      end else begin
        o.r[i] = t;
        o.q[i] = {s.q[i][NB-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic [2:0][DW-1:0] cen, con, ov;

  assign cen = {item_i.center_z, item_i.center_y, item_i.center_x};
  assign con = {item_i.contact_z, item_i.contact_y, item_i.contact_x};
  assign ov  = {item_i.other_vel_z, item_i.other_vel_y, item_i.other_vel_x};

  logic [2:0][MAGW-1:0] diff_q;
  logic [2:0][VRW-1:0]  vr1_q;
  logic [2:0][MAGW-1:0] mag;
  logic [MAGW-1:0]      orv;
  logic [1:0]           sh;
  logic [2:0]           neg2;
  logic [2:0]           neg_q [2:4];
  side_t                side2_d;
  side_t                side2_q, side3_q, side4_q;
  logic [2:0][2*PMW-1:0] sqr_q;
  logic [SUMW-1:0]      sum_q;
  logic                 v1_q, v2_q, v3_q, v4_q;

  sq_t                  sq_init;
  sq_t                  sqs_q [1:LENW];
  side_t                sds_q [1:LENW];
  logic [2:0]           sng_q [1:LENW];
  logic                 vs_q  [1:LENW];

  logic [LENW-1:0]      len0;
  logic [PMW+FRAC_BITS-1:0] num0 [3];
  dv_t                  dv_init;
  dv_t                  dvs_q  [1:NB];
  logic [LENW-1:0]      len_q  [1:NB];
  side_t                sdd_q  [1:NB];
  logic [2:0]           dng_q  [1:NB];
  logic                 vd_q   [1:NB];

  // magnitudes and common prescale
  always_comb begin
    orv = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i]  = diff_q[i][MAGW-1] ? MAGW'(-diff_q[i]) : diff_q[i];
      neg2[i] = diff_q[i][MAGW-1];
      orv     = orv | mag[i];
    end
    if (orv[MAGW-1]) begin
      sh = 2'd3;
    end else if (orv[MAGW-2]) begin
      sh = 2'd2;
    end else if (orv[MAGW-3]) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end
    for (int i = 0; i < 3; i++) begin
      side2_d.pm[i] = PMW'(mag[i] >> sh);
    end
    side2_d.vr    = vr1_q;
    side2_d.degen = (orv == '0);
  end

  always_comb begin
    sq_init.rem = sum_q;
    sq_init.res = '0;
  end

  // divide init: numerator is prescaled magnitude with frac bits appended
  always_comb begin
    len0 = (sqs_q[LENW].res == '0) ? LENW'(1) : sqs_q[LENW].res;
    for (int i = 0; i < 3; i++) begin
      num0[i]      = {sds_q[LENW].pm[i], {FRAC_BITS{1'b0}}};
      dv_init.r[i] = (LENW+1)'(num0[i] >> NB);
      dv_init.l[i] = num0[i][NB-1:0];
      dv_init.q[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      diff_q[i] <= {cen[i][DW-1], cen[i]} - {con[i][DW-1], con[i]};
      vr1_q[i]  <= {vel_i[i][DW-1], vel_i[i]} - {ov[i][DW-1], ov[i]};
      sqr_q[i]  <= side2_q.pm[i] * side2_q.pm[i];
    end
    side2_q  <= side2_d;
    neg_q[2] <= neg2;
    side3_q  <= side2_q;
    neg_q[3] <= neg_q[2];
    sum_q    <= SUMW'(sqr_q[0]) + SUMW'(sqr_q[1]) + SUMW'(sqr_q[2]);
    side4_q  <= side3_q;
    neg_q[4] <= neg_q[3];

    sqs_q[1] <= sqrt_step(sq_init, LENW - 1);
    sds_q[1] <= side4_q;
    sng_q[1] <= neg_q[4];
    for (int j = 2; j <= LENW; j++) begin
      sqs_q[j] <= sqrt_step(sqs_q[j-1], LENW - j);
      sds_q[j] <= sds_q[j-1];
      sng_q[j] <= sng_q[j-1];
    end

    dvs_q[1] <= div_step(dv_init, len0);
    len_q[1] <= len0;
    sdd_q[1] <= sds_q[LENW];
    dng_q[1] <= sng_q[LENW];
    for (int j = 2; j <= NB; j++) begin
      dvs_q[j] <= div_step(dvs_q[j-1], len_q[j-1]);
      len_q[j] <= len_q[j-1];
      sdd_q[j] <= sdd_q[j-1];
      dng_q[j] <= dng_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      for (int j = 1; j <= LENW; j++) begin
        vs_q[j] <= 1'b0;
      end
      for (int j = 1; j <= NB; j++) begin
        vd_q[j] <= 1'b0;
      end
    end else begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      vs_q[1] <= v4_q;
      for (int j = 2; j <= LENW; j++) begin
        vs_q[j] <= vs_q[j-1];
      end
      vd_q[1] <= vs_q[LENW];
      for (int j = 2; j <= NB; j++) begin
        vd_q[j] <= vd_q[j-1];
      end
    end
  end

  // signed normal from quotient magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_o.nrm[i] = dng_q[NB][i] ? NRMW'(-{1'b0, dvs_q[NB].q[i]})
                                  : NRMW'({1'b0, dvs_q[NB].q[i]});
    end
    dir_o.vr    = sdd_q[NB].vr;
    dir_o.degen = sdd_q[NB].degen;
  end

  assign valid_o = vd_q[NB];

endmodule

// File: hw/rtl/cif_mass.sv
// reduced mass path: product and sum of masses, pipelined long divide, delay to match direction path
// depends on cif_pkg
module cif_mass (
  input  logic                     clk_i,
  input  logic [cif_pkg::DW-1:0]   m1_i,
  input  logic [cif_pkg::DW-1:0]   m2_i,
  output logic [cif_pkg::MUW-1:0]  mu_o
);
  import cif_pkg::*;

  typedef struct packed {
    logic [MUW:0]   r;
    logic [MUW-1:0] l;
    logic [MUW-1:0] q;
    logic [MUW:0]   d;
    logic           dz;
  } dv_t;

  function automatic dv_t div_step(dv_t s);
    dv_t          o;
    logic [MUW+1:0] t;
    o = s;
    t = {s.r, s.l[MUW-1]};
    o.l = s.l << 1;
    if (t >= {1'b0, s.d}) begin
      o.r = (MUW+1)'(t - {1'b0, s.d});
      o.q = {s.q[MUW-2:0], 1'b1};
    end else begin
      o.r = (MUW+1)'(t);
      o.q = {s.q[MUW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [2*MUW-1:0] prod_q;
  logic [MUW:0]     msum_q;
  dv_t              dv_init;
  dv_t              dvs_q [1:MUW];
  logic [MUW-1:0]   pad_q [1:MASS_PAD];

  always_comb begin
    dv_init.r  = {1'b0, prod_q[2*MUW-1:MUW]};
    dv_init.l  = prod_q[MUW-1:0];
    dv_init.q  = '0;
    dv_init.d  = msum_q;
    dv_init.dz = (msum_q == '0);
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= m1_i * m2_i;
    msum_q   <= {1'b0, m1_i} + {1'b0, m2_i};
    dvs_q[1] <= div_step(dv_init);
    for (int j = 2; j <= MUW; j++) begin
      dvs_q[j] <= div_step(dvs_q[j-1]);
    end
    // both masses zero gives zero reduced mass
    pad_q[1] <= dvs_q[MUW].dz ? '0 : dvs_q[MUW].q;
    for (int j = 2; j <= MASS_PAD; j++) begin
      pad_q[j] <= pad_q[j-1];
    end
  end

  assign mu_o = pad_q[MASS_PAD];

endmodule

// File: hw/rtl/cif_imp.sv
// impulse path: dot product, restitution and reduced mass scaling, pipelined divide by time step
// depends on cif_pkg
module cif_imp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  cif_pkg::dir_t             dir_i,
  input  logic [cif_pkg::MUW-1:0]   mu_i,
  input  logic [cif_pkg::RESTW-1:0] restitution_i,
  input  logic [cif_pkg::DTW-1:0]   time_step_i,
  output logic                      valid_o,
  output cif_pkg::imp_t             imp_o
);
  import cif_pkg::*;

  localparam int PRW = NUMW + MUW;
  localparam int JCW = (PRW > JW) ? PRW : JW;
  localparam logic [JCW-1:0] JCAP = JCW'(1) << (JW - 1);

  typedef struct packed {
    logic [2:0][NRMW-1:0] nrm;
    logic                 degen;
    logic [MUW-1:0]       mu;
  } side_t;

  typedef struct packed {
    logic [DTW-1:0]       r;
    logic [QB-1:0]        l;
    logic [QB-1:0]        q;
    logic                 ovf;
    logic [2:0][NRMW-1:0] nrm;
    logic                 degen;
  } dv_t;

  function automatic dv_t div_step(dv_t s, logic [DTW-1:0] dt);
    dv_t          o;
    logic [DTW:0] t;
    o = s;
    t = {s.r, s.l[QB-1]};
    o.l = s.l << 1;
    if (t >= {1'b0, dt}) begin
      o.r = DTW'(t - {1'b0, dt});
      o.q = {s.q[QB-2:0], 1'b1};
    end else begin
      o.r = DTW'(t);
      o.q = {s.q[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  side_t                s_q [1:7];
  logic                 pv_q [1:8];
  logic [2:0][PRODW-1:0] prd_q;
  logic [DOTW-1:0]      dot_q;
  logic [DOTW-1:0]      absdot;
  logic [ADW-1:0]       ad_q;
  logic [OW-1:0]        onee;
  logic [ADW+OW-1:0]    nprod;
  logic [NUMW-1:0]      num_q;
  logic [2*MUW-1:0]     pl_q;
  logic [NUMW-1:0]      ph_q;
  logic [PRW-1:0]       prod_q;
  logic [JCW-1:0]       jf;
  logic [JW-1:0]        j_q;
  logic [DTW-1:0]       dte;
  dv_t                  dv_init;
  dv_t                  dv0_q;
  dv_t                  dvs_q [1:QB];
  logic                 vd_q  [1:QB];

  always_comb begin
    absdot = dot_q[DOTW-1] ? DOTW'(-dot_q) : dot_q;
    onee   = OW'(OW'(1) << FRAC_BITS) + OW'(restitution_i);
    nprod  = ad_q * onee;
    jf     = JCW'(prod_q >> FRAC_BITS);
    // zero time step counts as one lsb
    dte    = (time_step_i == '0) ? DTW'(1) : time_step_i;
  end

  // divide init: a quotient too wide for QB bits is flagged and saturates to the force limit
  always_comb begin
    dv_init.ovf   = j_q[JW-1:MUW] >= (JW-MUW)'(dte);
    dv_init.r     = dv_init.ovf ? '0 : DTW'(j_q[JW-1:MUW]);
    dv_init.l     = {j_q[MUW-1:0], {FRAC_BITS{1'b0}}};
    dv_init.q     = '0;
    dv_init.nrm   = s_q[7].nrm;
    dv_init.degen = s_q[7].degen;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      prd_q[i] <= PRODW'($signed(dir_i.vr[i]) * $signed(dir_i.nrm[i]));
    end
    s_q[1].nrm   <= dir_i.nrm;
    s_q[1].degen <= dir_i.degen;
    s_q[1].mu    <= mu_i;
    for (int j = 2; j <= 7; j++) begin
      s_q[j] <= s_q[j-1];
    end
    dot_q  <= DOTW'($signed(prd_q[0])) + DOTW'($signed(prd_q[1]))
            + DOTW'($signed(prd_q[2]));
    ad_q   <= ADW'(absdot >> FRAC_BITS);
    num_q  <= NUMW'(nprod >> FRAC_BITS);
    pl_q   <= num_q[MUW-1:0] * s_q[4].mu;
    ph_q   <= num_q[NUMW-1:MUW] * s_q[4].mu;
    prod_q <= PRW'(pl_q) + (PRW'(ph_q) << MUW);
    j_q    <= JW'((jf > JCAP) ? JCAP : jf);
    dv0_q  <= dv_init;
    dvs_q[1] <= div_step(dv0_q, dte);
    for (int j = 2; j <= QB; j++) begin
      dvs_q[j] <= div_step(dvs_q[j-1], dte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 1; j <= 8; j++) begin
        pv_q[j] <= 1'b0;
      end
      for (int j = 1; j <= QB; j++) begin
        vd_q[j] <= 1'b0;
      end
    end else begin
      pv_q[1] <= valid_i;
      for (int j = 2; j <= 8; j++) begin
        pv_q[j] <= pv_q[j-1];
      end
      vd_q[1] <= pv_q[8];
      for (int j = 2; j <= QB; j++) begin
        vd_q[j] <= vd_q[j-1];
      end
    end
  end

  always_comb begin
    imp_o.fmag  = dvs_q[QB].ovf ? (FMW'(1) << QB) : FMW'(dvs_q[QB].q);
    imp_o.nrm   = dvs_q[QB].nrm;
    imp_o.degen = dvs_q[QB].degen;
  end

  assign valid_o = vd_q[QB];

endmodule

// File: hw/rtl/cif_force.sv
// force components: magnitude times normal, saturation to 32 bits, status and result register
// depends on cif_pkg
module cif_force (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cif_pkg::imp_t      imp_i,
  output logic               valid_o,
  output cif_pkg::out_item_t res_o
);
  import cif_pkg::*;

  localparam int FPW = FMW + NB - FRAC_BITS;
  localparam logic [FPW-1:0] NEG_LIM = FPW'(1) << 31;
  localparam logic [FPW-1:0] POS_LIM = (FPW'(1) << 31) - FPW'(1);

  logic [2:0][NB-1:0]    an;
  logic [2:0][FMW+NB-1:0] fprod;
  logic [2:0][FPW-1:0]   fp_q;
  logic [2:0]            neg_q;
  logic                  degen_q;
  logic                  v1_q;
  logic [2:0][DW-1:0]    f;
  logic [2:0]            sat;
  out_item_t             res_d;
  out_item_t             res_q;
  logic                  valid_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      an[i]    = imp_i.nrm[i][NRMW-1] ? NB'(-imp_i.nrm[i]) : NB'(imp_i.nrm[i]);
      fprod[i] = imp_i.fmag * an[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (neg_q[i]) begin
        sat[i] = fp_q[i] > NEG_LIM;
        f[i]   = sat[i] ? 32'h8000_0000 : DW'(-fp_q[i][DW-1:0]);
      end else begin
        sat[i] = fp_q[i] > POS_LIM;
        f[i]   = sat[i] ? 32'h7fff_ffff : fp_q[i][DW-1:0];
      end
    end
    if (degen_q) begin
      res_d.force_x = '0;
      res_d.force_y = '0;
      res_d.force_z = '0;
      res_d.status  = STATUS_DEGEN;
    end else begin
      res_d.force_x = f[0];
      res_d.force_y = f[1];
      res_d.force_z = f[2];
      res_d.status  = (sat != 3'b000) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      fp_q[i]  <= FPW'(fprod[i] >> FRAC_BITS);
      neg_q[i] <= imp_i.nrm[i][NRMW-1];
    end
    degen_q <= imp_i.degen;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      valid_q <= v1_q;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: hw/rtl/contact_impulse_force_top.sv
// top level of the contact impulse force pipeline: configuration registers and stage wiring
// depends on cif_pkg, cif_dir, cif_mass, cif_imp, cif_force
//
// channel        | direction | handshake                  | payload
// ---------------+-----------+----------------------------+-------------------------------
// contact in     | in        | start / busy (busy tied 0) | in_i   (cif_pkg::in_item_t)
// force out      | out       | result_valid_o strobe      | res_o  (cif_pkg::out_item_t)
// configuration  | in        | cfg_we_i, cfg_idx_i        | cfg_data_i (32 bit)
//
// one contact transaction enters per cycle; busy never rises
// the bit-serial stages are 31 square root steps, FRAC_BITS + 1 normal
// divide steps and 32 + FRAC_BITS time step divide steps, one bit per stage
// the pipeline never stalls: the receiver takes every strobe, valid bits ride with the data
// reset clears all valid bits and loads the configuration reset values
module contact_impulse_force_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // contact transaction
  input  logic                         start,
  output logic                         busy,
  input  cif_pkg::in_item_t            in_i,
  // force transaction
  output logic                         result_valid_o,
  output cif_pkg::out_item_t           res_o,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [cif_pkg::CFG_IDXW-1:0] cfg_idx_i,
  input  logic [cif_pkg::DW-1:0]       cfg_data_i
);
  import cif_pkg::*;

  logic [RESTW-1:0] rest_q;
  vel_t             vel_q;
  logic [DTW-1:0]   ts_q;

  logic             dir_valid;
  dir_t             dir;
  logic [MUW-1:0]   mu;
  logic             imp_valid;
  imp_t             imp;

  // configuration registers; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= REST_RST;
      vel_q  <= '0;
      ts_q   <= TS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RESTITUTION: rest_q   <= cfg_data_i[RESTW-1:0];
        REG_BODY_VEL_X:  vel_q[0] <= cfg_data_i;
        REG_BODY_VEL_Y:  vel_q[1] <= cfg_data_i;
        REG_BODY_VEL_Z:  vel_q[2] <= cfg_data_i;
        REG_TIME_STEP:   ts_q     <= cfg_data_i[DTW-1:0];
        default: ;
      endcase
    end
  end

  // fully pipelined, so a new contact is always taken
  assign busy = 1'b0;

  // direction, normal and relative velocity
  cif_dir u_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .item_i  (in_i),
    .vel_i   (vel_q),
    .valid_o (dir_valid),
    .dir_o   (dir)
  );

  // reduced mass runs alongside and lands in step with the normal
  cif_mass u_mass (
    .clk_i (clk_i),
    .m1_i  (in_i.mass_self),
    .m2_i  (in_i.mass_other),
    .mu_o  (mu)
  );

  // dot product, impulse and force magnitude
  cif_imp u_imp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (dir_valid),
    .dir_i         (dir),
    .mu_i          (mu),
    .restitution_i (rest_q),
    .time_step_i   (ts_q),
    .valid_o       (imp_valid),
    .imp_o         (imp)
  );

  // per-axis force, saturation and status
  cif_force u_force (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (imp_valid),
    .imp_i   (imp),
    .valid_o (result_valid_o),
    .res_o   (res_o)
  );

endmodule
